FILE: rtl/hst_pkg.sv
package hst_pkg;

	localparam int DEPTH_DEF   = 64;
	localparam int VALUE_W_DEF = 32;

	localparam int FUNC_W   = 3;
	localparam int HANDLE_W = 7;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 7;

	localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 7'd64;

	localparam logic [FUNC_W-1:0] FN_PUT       = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_GET       = 3'd2;
	localparam logic [FUNC_W-1:0] FN_ITER_INIT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_ITER_NEXT = 3'd4;
	localparam logic [FUNC_W-1:0] FN_ITER_DEL  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_END  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO = 3'd4;

endpackage

FILE: rtl/hst_ram.sv
module hst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/hst_find.sv
module hst_find #(
	parameter int DEPTH = 64,
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int SZ_W = $clog2(DEPTH + 1)
) (
	input  logic [DEPTH-1:0] vec,
	input  logic [SZ_W-1:0]  lo,
	output logic             hit_lo,
	output logic [IW-1:0]    idx_lo
);

	// Lowest set bit at or above lo. Two of these, one with lo at zero,
	// form a rotating priority encoder.
	always_comb begin
		hit_lo = 1'b0;
		idx_lo = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (vec[i] && SZ_W'(i) >= lo) begin
				hit_lo = 1'b1;
				idx_lo = IW'(i);
			end
		end
	end

endmodule

FILE: rtl/handle_slot_table_core.sv
// Handle slot table. Pulse start while busy is low to issue one command; the
// result appears in the next cycle on out_handle, out_value, status and
// iter_has_more for exactly one cycle, marked by done, and cannot be held
// off. A command passes through the accept cycle, in which an
// occupancy bitmap and a rotating priority encoder pick the slot, and the
// cycle of the slot memory's registered read, in which a put writes its
// value back. busy is high during that read cycle. The slot store is
// empty right after reset with no clearing pass, since the occupancy bitmap
// decides which entries hold data. table_size may be written through the
// cfg channel, which is always ready, only while no command is in flight.
module handle_slot_table_core
	import hst_pkg::*;
#(
	parameter int DEPTH   = DEPTH_DEF,
	parameter int VALUE_W = VALUE_W_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [FUNC_W-1:0]   func,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [DATA_W-1:0]   value,
	output logic                done,
	output logic [HANDLE_W-1:0] out_handle,
	output logic [DATA_W-1:0]   out_value,
	output logic [STATUS_W-1:0] status,
	output logic                iter_has_more,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data
);

	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SZ_W = $clog2(DEPTH + 1);
	localparam int CW   = (SZ_W > HANDLE_W) ? SZ_W : HANDLE_W;

	logic [CFG_W-1:0]   table_size_q;
	logic [DEPTH-1:0]   occ_q;
	logic [SZ_W-1:0]    used_q;
	logic [IW-1:0]      next_q;
	logic [IW-1:0]      cursor_q;
	logic               cur_valid_q;
	logic [SZ_W-1:0]    left_q;

	logic               valid_s1;
	logic               show_s1;
	logic               wr_s1;
	logic [IW-1:0]      idx_s1;
	logic [VALUE_W-1:0] wval_s1;
	logic [HANDLE_W-1:0] oh_s1;
	logic [STATUS_W-1:0] st_s1;

	logic               accept;
	logic [CW-1:0]      ts_ext;
	logic [SZ_W-1:0]    size;
	logic [DEPTH-1:0]   in_range;
	logic [VALUE_W-1:0] wval;
	logic [SZ_W-1:0]    put_lo;
	logic [SZ_W-1:0]    nxt_lo;
	logic               put_hit_lo, put_hit_any, nx_hit;
	logic [IW-1:0]      put_idx_lo, put_idx_any, nx_idx;
	logic [IW-1:0]      put_idx;
	logic [SZ_W-1:0]    put_inc;
	logic [IW-1:0]      hidx;
	logic               bad_handle;
	logic [IW-1:0]      raddr;
	logic [VALUE_W-1:0] rdata;

	assign accept    = start && !busy;
	assign busy      = valid_s1;
	assign cfg_ready = 1'b1;

	// Table size clamped to 1..DEPTH.
	assign ts_ext = CW'(table_size_q);
	always_comb begin
		if (ts_ext == '0) begin
			size = SZ_W'(1);
		end else if (ts_ext > CW'(DEPTH)) begin
			size = SZ_W'(DEPTH);
		end else begin
			size = SZ_W'(ts_ext);
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			in_range[i] = SZ_W'(i) < size;
		end
	end

	assign wval   = VALUE_W'(value);
	assign put_lo = (SZ_W'(next_q) < size) ? SZ_W'(next_q) : '0;
	assign nxt_lo = cur_valid_q ? SZ_W'(cursor_q) + SZ_W'(1) : '0;

	hst_find #(.DEPTH(DEPTH)) u_put_find (
		.vec   (~occ_q & in_range),
		.lo    (put_lo),
		.hit_lo(put_hit_lo),
		.idx_lo(put_idx_lo)
	);

	// Search from slot 0 for the wrap-around case.
	hst_find #(.DEPTH(DEPTH)) u_put_wrap (
		.vec   (~occ_q & in_range),
		.lo    (SZ_W'(0)),
		.hit_lo(put_hit_any),
		.idx_lo(put_idx_any)
	);

	hst_find #(.DEPTH(DEPTH)) u_next_find (
		.vec   (occ_q & in_range),
		.lo    (nxt_lo),
		.hit_lo(nx_hit),
		.idx_lo(nx_idx)
	);

	assign put_idx    = put_hit_lo ? put_idx_lo : put_idx_any;
	assign put_inc    = SZ_W'(put_idx) + SZ_W'(1);
	assign hidx       = IW'(CW'(handle) - CW'(1));
	assign bad_handle = (handle == '0) || (CW'(handle) > CW'(size));

	always_comb begin
		case (func)
			FN_ITER_NEXT: raddr = nx_idx;
			FN_ITER_DEL:  raddr = cursor_q;
			default:      raddr = hidx;
		endcase
	end

	hst_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_slots (
		.clk  (clk),
		.we   (valid_s1 && wr_s1),
		.waddr(idx_s1),
		.wdata(wval_s1),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			table_size_q <= cfg_data;
		end
	end

	// Control state is updated at accept; the slot data follows in the next cycle,
	// while busy keeps the next command out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			used_q      <= '0;
			next_q      <= '0;
			cursor_q    <= '0;
			cur_valid_q <= 1'b0;
			left_q      <= '0;
			valid_s1    <= 1'b0;
			show_s1     <= 1'b0;
			wr_s1       <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				show_s1 <= 1'b0;
				wr_s1   <= 1'b0;
				case (func)
					FN_PUT: begin
						if (wval != '0 && put_hit_any) begin
							wr_s1          <= 1'b1;
							occ_q[put_idx] <= 1'b1;
							used_q         <= used_q + SZ_W'(1);
							next_q         <= (put_inc >= size) ? '0 : IW'(put_inc);
						end
					end
					FN_REMOVE: begin
						if (!bad_handle) begin
							show_s1 <= occ_q[hidx];
							next_q  <= hidx;
							if (occ_q[hidx]) begin
								occ_q[hidx] <= 1'b0;
								used_q      <= used_q - SZ_W'(1);
							end
						end
					end
					FN_GET: begin
						if (!bad_handle) begin
							show_s1 <= occ_q[hidx];
						end
					end
					FN_ITER_INIT: begin
						cur_valid_q <= 1'b0;
						cursor_q    <= '0;
						left_q      <= used_q;
					end
					FN_ITER_NEXT: begin
						if (left_q != '0 && nx_hit) begin
							show_s1     <= 1'b1;
							cursor_q    <= nx_idx;
							cur_valid_q <= 1'b1;
							left_q      <= left_q - SZ_W'(1);
						end else begin
							left_q <= '0;
						end
					end
					FN_ITER_DEL: begin
						if (cur_valid_q && SZ_W'(cursor_q) < size) begin
							show_s1 <= occ_q[cursor_q];
							next_q  <= cursor_q;
							if (occ_q[cursor_q]) begin
								occ_q[cursor_q] <= 1'b0;
								used_q          <= used_q - SZ_W'(1);
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1  <= put_idx;
			wval_s1 <= wval;
			oh_s1   <= '0;
			st_s1   <= ST_OK;
			case (func)
				FN_PUT: begin
					if (wval == '0) begin
						st_s1 <= ST_ZERO;
					end else if (!put_hit_any) begin
						st_s1 <= ST_FULL;
					end else begin
						oh_s1 <= HANDLE_W'(put_inc);
					end
				end
				FN_REMOVE, FN_GET: begin
					if (bad_handle) begin
						st_s1 <= ST_BAD;
					end
				end
				FN_ITER_NEXT: begin
					if (left_q != '0 && nx_hit) begin
						oh_s1 <= HANDLE_W'(SZ_W'(nx_idx) + SZ_W'(1));
					end else begin
						st_s1 <= ST_END;
					end
				end
				FN_ITER_DEL: begin
					if (!cur_valid_q || SZ_W'(cursor_q) >= size) begin
						st_s1 <= ST_BAD;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done          = valid_s1;
	assign out_handle    = oh_s1;
	assign out_value     = show_s1 ? DATA_W'(rdata) : '0;
	assign status        = st_s1;
	assign iter_has_more = left_q != '0;

endmodule

FILE: bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hst_pkg::*;

	// The two function codes that the block must ignore.
	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

	localparam int CYCLE_LIMIT = 150000;
	localparam int SETTLE_CYCLES = 10;
	localparam int PRINT_CAP = 30;

	typedef enum logic [1:0] {
		REQ_CMD,
		REQ_CFG,
		REQ_DRAIN
	} req_kind_t;

	typedef struct packed {
		req_kind_t           kind;
		logic [FUNC_W-1:0]   fn;
		logic [HANDLE_W-1:0] hnd;
		logic [DATA_W-1:0]   val;
		logic [CFG_W-1:0]    size;
	} table_req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] hnd;
		logic [DATA_W-1:0]   val;
		logic [STATUS_W-1:0] st;
		logic                more;
	} slot_reply_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [FUNC_W-1:0]   func = '0;
	logic [HANDLE_W-1:0] handle = '0;
	logic [DATA_W-1:0]   value = '0;
	logic                done;
	logic [HANDLE_W-1:0] out_handle;
	logic [DATA_W-1:0]   out_value;
	logic [STATUS_W-1:0] status;
	logic                iter_has_more;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data = '0;

	handle_slot_table_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.handle       (handle),
		.value        (value),
		.done         (done),
		.out_handle   (out_handle),
		.out_value    (out_value),
		.status       (status),
		.iter_has_more(iter_has_more),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Shadow copy of the table state.
	logic [DATA_W-1:0] shadow_slots [DEPTH_DEF];
	int                used_slots = 0;
	int                free_ptr = 0;
	int                walk_pos = 0;
	bit                walk_ok = 1'b0;
	int                walk_left = 0;
	logic [CFG_W-1:0]  size_reg = TABLE_SIZE_RST;

	table_req_t  cmd_backlog [$];
	slot_reply_t pending_replies [$];

	table_req_t cur_req = '0;
	bit         offering = 1'b0;
	bit         burst = 1'b0;
	int         hold_off = 0;

	int cycle_count = 0;
	int mismatches = 0;
	int cmds_sent = 0;
	int cfg_writes = 0;
	int results_seen = 0;
	int status_hits [5] = '{default: 0};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int clamp_size(logic [CFG_W-1:0] s);
		if (s == '0)
			return 1;
		if (s > DEPTH_DEF)
			return DEPTH_DEF;
		return int'(s);
	endfunction

	// Clears one slot and aims the next free search at it. An empty slot
	// leaves the occupancy count alone.
	function automatic logic [DATA_W-1:0] vacate(int idx);
		logic [DATA_W-1:0] old;
		old = shadow_slots[idx];
		shadow_slots[idx] = '0;
		if (old != '0 && used_slots > 0)
			used_slots--;
		free_ptr = idx;
		return old;
	endfunction

	function automatic slot_reply_t table_step(logic [FUNC_W-1:0] fn,
		logic [HANDLE_W-1:0] hnd, logic [DATA_W-1:0] val);
		slot_reply_t r;
		int size;
		int first;
		int idx;
		bit hit;
		r = '0;
		r.st = ST_OK;
		size = clamp_size(size_reg);
		hit = 1'b0;
		case (fn)
			FN_PUT: begin
				if (val == '0) begin
					r.st = ST_ZERO;
				end else begin
					first = (free_ptr < size) ? free_ptr : 0;
					r.st = ST_FULL;
					for (int k = 0; k < size && !hit; k++) begin
						idx = (first + k) % size;
						if (shadow_slots[idx] == '0) begin
							shadow_slots[idx] = val;
							used_slots++;
							free_ptr = (idx + 1 >= size) ? 0 : idx + 1;
							r.hnd = HANDLE_W'(idx + 1);
							r.st = ST_OK;
							hit = 1'b1;
						end
					end
				end
			end
			FN_REMOVE, FN_GET: begin
				if (hnd == '0 || hnd > size)
					r.st = ST_BAD;
				else if (fn == FN_REMOVE)
					r.val = vacate(int'(hnd) - 1);
				else
					r.val = shadow_slots[int'(hnd) - 1];
			end
			FN_ITER_INIT: begin
				walk_ok = 1'b0;
				walk_pos = 0;
				walk_left = used_slots;
			end
			FN_ITER_NEXT: begin
				r.st = ST_END;
				if (walk_left != 0) begin
					first = walk_ok ? walk_pos + 1 : 0;
					for (int i = first; i < size && !hit; i++) begin
						if (shadow_slots[i] != '0) begin
							walk_pos = i;
							walk_ok = 1'b1;
							walk_left--;
							r.hnd = HANDLE_W'(i + 1);
							r.val = shadow_slots[i];
							r.st = ST_OK;
							hit = 1'b1;
						end
					end
				end
				if (r.st == ST_END)
					walk_left = 0;
			end
			FN_ITER_DEL: begin
				if (!walk_ok || walk_pos >= size)
					r.st = ST_BAD;
				else
					r.val = vacate(walk_pos);
			end
			default: begin
			end
		endcase
		r.more = (walk_left != 0);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch %0d at cycle %0d: %s got %0h expected %0h",
				mismatches, cycle_count, what, got, want);
	endtask

	task automatic push_cmd(logic [FUNC_W-1:0] fn, logic [HANDLE_W-1:0] hnd,
		logic [DATA_W-1:0] val);
		table_req_t q;
		q = '0;
		q.kind = REQ_CMD;
		q.fn = fn;
		q.hnd = hnd;
		q.val = val;
		cmd_backlog.push_back(q);
	endtask

	task automatic push_cfg(logic [CFG_W-1:0] s);
		table_req_t q;
		q = '0;
		q.kind = REQ_CFG;
		q.size = s;
		cmd_backlog.push_back(q);
	endtask

	task automatic push_drain();
		table_req_t q;
		q = '0;
		q.kind = REQ_DRAIN;
		cmd_backlog.push_back(q);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return 32'd1;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [HANDLE_W-1:0] any_handle();
		return HANDLE_W'($urandom_range(0, 127));
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_handle(int size);
		case ($urandom_range(0, 15))
			0: return any_handle();
			1: return '0;
			2: return HANDLE_W'(size);
			default: return HANDLE_W'($urandom_range(1, size));
		endcase
	endfunction

	// One phase of random traffic at a fixed table size. Iterator walks are
	// emitted as whole sequences so that they reach the later slots.
	task automatic random_phase(int n_items, logic [CFG_W-1:0] s);
		int size;
		int put_pct;
		int r;
		int n;
		int walk_len;
		size = clamp_size(s);
		put_pct = $urandom_range(25, 60);
		n = 0;
		while (n < n_items) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 79) == 0)
				push_drain();
			if (r < put_pct) begin
				push_cmd(FN_PUT, pick_handle(size), pick_value());
				n++;
			end else if (r < put_pct + 18) begin
				push_cmd(FN_REMOVE, pick_handle(size), $urandom);
				n++;
			end else if (r < put_pct + 28) begin
				push_cmd(FN_GET, pick_handle(size), $urandom);
				n++;
			end else if (r < put_pct + 34) begin
				push_cmd(FN_ITER_INIT, any_handle(), $urandom);
				n++;
				if ($urandom_range(0, 5) == 0)
					walk_len = size + 2;
				else
					walk_len = $urandom_range(1, (size < 12 ? size : 12) + 2);
				repeat (walk_len) begin
					push_cmd(FN_ITER_NEXT, any_handle(), $urandom);
					n++;
					if ($urandom_range(0, 2) == 0) begin
						push_cmd(FN_ITER_DEL, any_handle(), $urandom);
						n++;
					end
				end
			end else begin
				case ($urandom_range(0, 3))
					0: push_cmd(FN_ITER_NEXT, any_handle(), $urandom);
					1: push_cmd(FN_ITER_DEL, any_handle(), $urandom);
					2: push_cmd(FN_SPARE_A, any_handle(), $urandom);
					default: push_cmd(FN_SPARE_B, any_handle(), $urandom);
				endcase
				n++;
			end
		end
	endtask

	initial begin
		logic [CFG_W-1:0] sizes [$];
		foreach (shadow_slots[i])
			shadow_slots[i] = '0;

		// Directed part at the reset size.
		push_cmd(FN_GET, 7'd1, '0);
		push_cmd(FN_PUT, 7'd0, '0);
		push_cmd(FN_PUT, 7'd0, '1);
		push_cmd(FN_PUT, 7'd0, 32'd1);
		push_cmd(FN_PUT, 7'd0, 32'h8000_0000);
		push_cmd(FN_GET, 7'd0, '0);
		push_cmd(FN_GET, 7'd65, '0);
		push_cmd(FN_GET, 7'd127, '0);
		push_cmd(FN_GET, 7'd1, '0);
		push_cmd(FN_REMOVE, 7'd2, '0);
		push_cmd(FN_REMOVE, 7'd2, '0);
		push_cmd(FN_REMOVE, 7'd0, '0);
		push_cmd(FN_ITER_NEXT, 7'd0, '0);
		push_cmd(FN_ITER_DEL, 7'd0, '0);
		push_cmd(FN_ITER_INIT, 7'd0, '0);
		push_cmd(FN_ITER_NEXT, 7'd0, '0);
		push_cmd(FN_ITER_DEL, 7'd0, '0);
		push_cmd(FN_ITER_NEXT, 7'd0, '0);
		push_cmd(FN_ITER_NEXT, 7'd0, '0);
		push_cmd(FN_SPARE_A, 7'd127, '1);
		push_cmd(FN_SPARE_B, 7'd64, '1);
		push_cmd(FN_PUT, 7'd0, 32'd5);
		push_cmd(FN_ITER_INIT, 7'd0, '0);
		push_cmd(FN_ITER_NEXT, 7'd0, '0);
		push_cmd(FN_ITER_NEXT, 7'd0, '0);
		// Shrink below the iterator cursor: removing the current slot must fail,
		// and the third slot stays stored but out of reach.
		push_cfg(7'd2);
		push_cmd(FN_ITER_DEL, 7'd0, '0);
		push_cmd(FN_PUT, 7'd0, 32'h1234_5678);
		push_cmd(FN_PUT, 7'd0, 32'h0000_00ff);
		push_cmd(FN_REMOVE, 7'd3, '0);

		sizes = '{7'd64, 7'd1, 7'd2, 7'd4, 7'd0, 7'd127, 7'd8, 7'd3, 7'd64, 7'd16};
		sizes.push_back(CFG_W'($urandom_range(1, 64)));
		sizes.push_back(CFG_W'($urandom_range(1, 64)));
		foreach (sizes[i]) begin
			push_cfg(sizes[i]);
			random_phase(125, sizes[i]);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || offering || pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d commands and %0d table size writes, %0d results checked.",
			cmds_sent, cfg_writes, results_seen);
		$display("Status mix: ok %0d, full %0d, bad handle %0d, end %0d, zero %0d.",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Driver: offers one item at a time from the backlog. Size writes and
	// drain points wait until every outstanding result has come back.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				pending_replies.push_back(table_step(func, handle, value));
				cmds_sent++;
				offering = 1'b0;
				if ($urandom_range(0, 39) == 0)
					burst = ~burst;
				hold_off = burst ? 0 : $urandom_range(0, 4);
			end
			if (cfg_valid && cfg_ready) begin
				size_reg = cfg_data;
				cfg_writes++;
				offering = 1'b0;
				hold_off = $urandom_range(0, 4);
			end
			if (!offering) begin
				if (hold_off > 0) begin
					hold_off--;
				end else if (cmd_backlog.size() != 0) begin
					if (cmd_backlog[0].kind == REQ_CMD) begin
						cur_req = cmd_backlog.pop_front();
						offering = 1'b1;
					end else if (pending_replies.size() == 0 && !done && !busy) begin
						cur_req = cmd_backlog.pop_front();
						offering = (cur_req.kind == REQ_CFG);
					end
				end
			end
			start <= offering && cur_req.kind == REQ_CMD;
			cfg_valid <= offering && cur_req.kind == REQ_CFG;
			func <= cur_req.fn;
			handle <= cur_req.hnd;
			value <= cur_req.val;
			cfg_data <= cur_req.size;
		end
	end

	// Monitor: every strobed result is checked against the oldest prediction.
	always @(posedge clk) begin
		slot_reply_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_replies.size() == 0) begin
				report_mismatch("result with nothing expected, status", 64'(status), '0);
			end else begin
				want = pending_replies.pop_front();
				if (out_handle !== want.hnd)
					report_mismatch("out_handle", 64'(out_handle), 64'(want.hnd));
				if (out_value !== want.val)
					report_mismatch("out_value", 64'(out_value), 64'(want.val));
				if (status !== want.st)
					report_mismatch("status", 64'(status), 64'(want.st));
				if (iter_has_more !== want.more)
					report_mismatch("iter_has_more", 64'(iter_has_more), 64'(want.more));
				if (want.st <= ST_ZERO)
					status_hits[want.st]++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule
